@@ rtl/core/hilditch_thinning_pass_defines.svh @@
// Assertion helpers used by the checker file
`ifndef HILDITCH_THINNING_PASS_DEFINES_SVH
`define HILDITCH_THINNING_PASS_DEFINES_SVH

// Clocked check, muted while reset is held
`define HILT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked check that also holds through reset
`define HILT_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

@@ rtl/core/hilt_pkg.sv @@
package hilt_pkg;

    // Image bounds
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    // Counter and register widths
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int WIDTH_REG_W  = COL_W + 1;
    localparam int HEIGHT_REG_W = ROW_W + 1;
    localparam int CFG_DATA_W   = (WIDTH_REG_W > HEIGHT_REG_W) ? WIDTH_REG_W : HEIGHT_REG_W;
    localparam int CFG_ADDR_W   = 1;

    // Line store: rows R-1, R-2, R-3 of one column
    localparam int LINE_W = 3;

    // 4x4 window, bit i*4+j is row i, column j
    localparam int WIN_N = 4;
    localparam int WIN_W = WIN_N * WIN_N;

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Window held between the front end and the rule stage
    typedef struct packed {
        logic [WIN_W-1:0] window;
        logic             last;
    } hilt_stage_t;

endpackage

@@ rtl/core/hilt_ram.sv @@
module hilt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one entry, read one entry (old data on a collision)
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/hilt_front.sv @@
module hilt_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_fire,
    input  logic                                pixel_in,
    input  logic                                flush,
    input  logic [hilt_pkg::WIDTH_REG_W-1:0]    eff_width,
    input  logic [hilt_pkg::HEIGHT_REG_W-1:0]   eff_height,
    input  logic                                adv,
    output logic                                stage_valid,
    output hilt_pkg::hilt_stage_t               stage
);

    logic [hilt_pkg::COL_W-1:0]  in_col_reg, in_col_next;
    logic [1:0]                  in_row_reg, in_row_next;
    logic [hilt_pkg::COL_W-1:0]  out_col_reg, out_col_next;
    logic [hilt_pkg::ROW_W-1:0]  out_row_reg, out_row_next;
    logic [hilt_pkg::WIN_W-1:0]  window_reg, window_next;
    logic                        fwd_valid_reg, fwd_valid_next;
    logic [hilt_pkg::LINE_W-1:0] fwd_data_reg;
    logic                        stage_valid_reg, stage_valid_next;
    hilt_pkg::hilt_stage_t       stage_reg, stage_next;

    logic [hilt_pkg::LINE_W-1:0] ram_rd_data;
    logic [hilt_pkg::LINE_W-1:0] old_col;
    logic [hilt_pkg::LINE_W-1:0] wr_data;
    logic [hilt_pkg::WIN_N-1:0]  col_bits;
    logic [hilt_pkg::WIN_W-1:0]  window_new;
    logic [hilt_pkg::WIN_N-1:0]  row_ok;
    logic [hilt_pkg::WIN_N-1:0]  col_ok;
    logic [hilt_pkg::WIN_W-1:0]  window_masked;
    logic [hilt_pkg::ROW_W+1:0]  row_pos [hilt_pkg::WIN_N];
    logic [hilt_pkg::COL_W+1:0]  col_pos [hilt_pkg::WIN_N];
    logic                        px;
    logic                        emit;
    logic                        in_col_wrap;
    logic                        out_col_wrap;
    logic                        out_last;

    // Line store, read ahead at the column the next transaction will use
    hilt_ram #(
        .WIDTH (hilt_pkg::LINE_W),
        .DEPTH (hilt_pkg::MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (s_fire),
        .wr_addr (in_col_reg),
        .wr_data (wr_data),
        .rd_addr (in_col_next),
        .rd_data (ram_rd_data)
    );

    // Column bits and the shifted window
    always_comb begin
        old_col  = fwd_valid_reg ? fwd_data_reg : ram_rd_data;
        px       = pixel_in & ~flush;
        col_bits = {px, old_col[0], old_col[1], old_col[2]};
        wr_data  = {old_col[1:0], px};
        for (int i = 0; i < hilt_pkg::WIN_N; i++) begin
            window_new[i*hilt_pkg::WIN_N +: hilt_pkg::WIN_N] =
                {col_bits[i], window_reg[i*hilt_pkg::WIN_N+1 +: hilt_pkg::WIN_N-1]};
        end
    end

    // Blank window positions that lie outside the image
    always_comb begin
        for (int i = 0; i < hilt_pkg::WIN_N; i++) begin
            row_pos[i] = (hilt_pkg::ROW_W+2)'(out_row_reg) + (hilt_pkg::ROW_W+2)'(i);
            col_pos[i] = (hilt_pkg::COL_W+2)'(out_col_reg) + (hilt_pkg::COL_W+2)'(i);
            row_ok[i]  = (row_pos[i] >= (hilt_pkg::ROW_W+2)'(2)) &&
                         (row_pos[i] < ((hilt_pkg::ROW_W+2)'(eff_height) +
                                        (hilt_pkg::ROW_W+2)'(2)));
            col_ok[i]  = (col_pos[i] >= (hilt_pkg::COL_W+2)'(2)) &&
                         (col_pos[i] < ((hilt_pkg::COL_W+2)'(eff_width) +
                                        (hilt_pkg::COL_W+2)'(2)));
        end
        for (int i = 0; i < hilt_pkg::WIN_N; i++) begin
            for (int j = 0; j < hilt_pkg::WIN_N; j++) begin
                window_masked[i*hilt_pkg::WIN_N + j] =
                    window_new[i*hilt_pkg::WIN_N + j] & row_ok[i] & col_ok[j];
            end
        end
    end

    // Position counters and the stage register
    always_comb begin
        emit = (in_row_reg == 2'd2) || ((in_row_reg == 2'd1) && (in_col_reg != '0));
        in_col_wrap  = ((hilt_pkg::WIDTH_REG_W)'(in_col_reg) +
                        (hilt_pkg::WIDTH_REG_W)'(1)) >= eff_width;
        out_col_wrap = ((hilt_pkg::WIDTH_REG_W)'(out_col_reg) +
                        (hilt_pkg::WIDTH_REG_W)'(1)) >= eff_width;
        out_last     = out_col_wrap &&
                       (((hilt_pkg::HEIGHT_REG_W)'(out_row_reg) +
                         (hilt_pkg::HEIGHT_REG_W)'(1)) >= eff_height);

        in_col_next      = in_col_reg;
        in_row_next      = in_row_reg;
        out_col_next     = out_col_reg;
        out_row_next     = out_row_reg;
        window_next      = window_reg;
        stage_next       = stage_reg;
        stage_valid_next = adv ? 1'b0 : stage_valid_reg;

        if (s_fire) begin
            window_next       = window_new;
            stage_next.window = window_masked;
            stage_next.last   = out_last;
            stage_valid_next  = emit;
            if (in_col_wrap) begin
                in_col_next = '0;
                if (in_row_reg != 2'd2) begin
                    in_row_next = in_row_reg + 2'd1;
                end
            end else begin
                in_col_next = in_col_reg + (hilt_pkg::COL_W)'(1);
            end
            if (emit) begin
                if (out_last) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end else if (out_col_wrap) begin
                    out_col_next = '0;
                    if (out_row_reg != '1) begin
                        out_row_next = out_row_reg + (hilt_pkg::ROW_W)'(1);
                    end
                end else begin
                    out_col_next = out_col_reg + (hilt_pkg::COL_W)'(1);
                end
            end
        end

        // Forward a write that collides with the look-ahead read
        fwd_valid_next = s_fire && (in_col_next == in_col_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg      <= '0;
            in_row_reg      <= '0;
            out_col_reg     <= '0;
            out_row_reg     <= '0;
            window_reg      <= '0;
            fwd_valid_reg   <= 1'b0;
            stage_valid_reg <= 1'b0;
        end else begin
            in_col_reg      <= in_col_next;
            in_row_reg      <= in_row_next;
            out_col_reg     <= out_col_next;
            out_row_reg     <= out_row_next;
            window_reg      <= window_next;
            fwd_valid_reg   <= fwd_valid_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        fwd_data_reg <= wr_data;
        stage_reg    <= stage_next;
    end

    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;

endmodule

@@ rtl/core/hilt_rule.sv @@
module hilt_rule (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  stage_valid,
    input  hilt_pkg::hilt_stage_t stage,
    input  logic                  out_ready,
    output logic                  adv,
    output logic                  out_valid,
    output logic                  pixel_out,
    output logic                  last_pixel,
    output logic                  frame_changed
);

    // Window cell, white outside the window
    function automatic logic cell_at(input logic [hilt_pkg::WIN_W-1:0] m,
                                     input int i, input int j);
        logic bit_val;
        bit_val = 1'b0;
        if (i >= 0 && i < hilt_pkg::WIN_N && j >= 0 && j < hilt_pkg::WIN_N) begin
            bit_val = m[i*hilt_pkg::WIN_N + j];
        end
        return bit_val;
    endfunction

    // Ring: up, up-left, left, down-left, down, down-right, right, up-right
    function automatic logic [7:0] ring_at(input logic [hilt_pkg::WIN_W-1:0] m,
                                           input int a, input int b);
        logic [7:0] p;
        p[0] = cell_at(m, a - 1, b);
        p[1] = cell_at(m, a - 1, b - 1);
        p[2] = cell_at(m, a, b - 1);
        p[3] = cell_at(m, a + 1, b - 1);
        p[4] = cell_at(m, a + 1, b);
        p[5] = cell_at(m, a + 1, b + 1);
        p[6] = cell_at(m, a, b + 1);
        p[7] = cell_at(m, a - 1, b + 1);
        return p;
    endfunction

    // True when the ring has exactly one white-to-black step
    function automatic logic one_crossing(input logic [7:0] p);
        logic [3:0] n;
        n = '0;
        for (int k = 0; k < 8; k++) begin
            n = n + {3'b000, ~p[k] & p[(k + 1) % 8]};
        end
        return n == 4'd1;
    endfunction

    logic                      out_valid_reg;
    logic                      pixel_reg, pixel_next;
    logic                      last_reg, last_next;
    logic                      changed_reg, changed_next;
    logic                      any_removed_reg, any_removed_next;
    logic [hilt_pkg::WIN_W-1:0] m;
    logic [7:0]                centre_ring;
    logic [3:0]                black_n;
    logic                      centre;
    logic                      up, left, down, right;
    logic                      c1, c2, c3, c4;
    logic                      removed;

    // Hilditch deletion test on the centre cell
    always_comb begin
        m           = stage.window;
        centre      = cell_at(m, 2, 2);
        centre_ring = ring_at(m, 2, 2);
        black_n     = 4'($countones(centre_ring));
        up          = cell_at(m, 1, 2);
        left        = cell_at(m, 2, 1);
        down        = cell_at(m, 3, 2);
        right       = cell_at(m, 2, 3);
        c1          = (black_n >= 4'd2) && (black_n <= 4'd6);
        c2          = one_crossing(centre_ring);
        c3          = !(up && left && right) || !one_crossing(ring_at(m, 1, 2));
        c4          = !(up && left && down) || !one_crossing(ring_at(m, 2, 1));
        removed     = centre && c1 && c2 && c3 && c4;
    end

    // Advance the stage into the output register when it is free
    always_comb begin
        adv              = !out_valid_reg || out_ready;
        pixel_next       = centre & ~removed;
        last_next        = stage.last;
        changed_next     = stage.last & (any_removed_reg | removed);
        any_removed_next = any_removed_reg;
        if (adv && stage_valid) begin
            any_removed_next = stage.last ? 1'b0 : (any_removed_reg | removed);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            any_removed_reg <= 1'b0;
        end else begin
            if (adv) begin
                out_valid_reg <= stage_valid;
            end
            any_removed_reg <= any_removed_next;
        end
    end

    // Hold the result payload until it is taken
    always_ff @(posedge aclk) begin
        if (adv && stage_valid) begin
            pixel_reg   <= pixel_next;
            last_reg    <= last_next;
            changed_reg <= changed_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_out     = pixel_reg;
    assign last_pixel    = last_reg;
    assign frame_changed = changed_reg;

endmodule

@@ rtl/core/hilditch_thinning_pass.sv @@
// Latency: a pixel's result leaves image_width+1 transactions after it, then passes
// the window stage and then the output register.
// Throughput: one pixel per cycle unless the output stalls; the line store has one
// read and one write port and the deletion test fits between the window stage and the
// output register. Reset: aresetn is synchronous, active low; counters, window and
// flags clear, the line store is not cleared, width and height return to 1024.
module hilditch_thinning_pass (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,     // [0] pixel_in, [7:1] zero
    input  logic                                s_tuser,     // [0] flush
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,     // [0] pixel_out, [7:1] zero
    output logic                                m_tlast,
    output logic                                m_tuser,     // [0] frame_changed
    input  logic                                cfg_wr_en,
    input  logic [hilt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [hilt_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    logic [hilt_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [hilt_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic [hilt_pkg::WIDTH_REG_W-1:0]  eff_width;
    logic [hilt_pkg::HEIGHT_REG_W-1:0] eff_height;
    logic                              s_fire;
    logic                              adv;
    logic                              stage_valid;
    hilt_pkg::hilt_stage_t             stage;
    logic                              pixel_out;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= (hilt_pkg::WIDTH_REG_W)'(1024);
            height_reg <= (hilt_pkg::HEIGHT_REG_W)'(1024);
        end else if (cfg_wr_en) begin
            unique case (hilt_pkg::cfg_reg_t'(cfg_addr))
                hilt_pkg::REG_IMAGE_WIDTH: begin
                    width_reg <= cfg_wr_data[hilt_pkg::WIDTH_REG_W-1:0];
                end
                hilt_pkg::REG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_wr_data[hilt_pkg::HEIGHT_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp width and height to their legal range
    always_comb begin
        if (width_reg == '0) begin
            eff_width = (hilt_pkg::WIDTH_REG_W)'(1);
        end else if (width_reg > (hilt_pkg::WIDTH_REG_W)'(hilt_pkg::MAX_WIDTH)) begin
            eff_width = (hilt_pkg::WIDTH_REG_W)'(hilt_pkg::MAX_WIDTH);
        end else begin
            eff_width = width_reg;
        end
        if (height_reg == '0) begin
            eff_height = (hilt_pkg::HEIGHT_REG_W)'(1);
        end else if (height_reg > (hilt_pkg::HEIGHT_REG_W)'(hilt_pkg::MAX_HEIGHT)) begin
            eff_height = (hilt_pkg::HEIGHT_REG_W)'(hilt_pkg::MAX_HEIGHT);
        end else begin
            eff_height = height_reg;
        end
    end

    // Accept while the window stage is empty or moving on
    assign s_tready = !stage_valid || adv;
    assign s_fire   = s_tvalid && s_tready;

    hilt_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_fire      (s_fire),
        .pixel_in    (s_tdata[0]),
        .flush       (s_tuser),
        .eff_width   (eff_width),
        .eff_height  (eff_height),
        .adv         (adv),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    hilt_rule u_rule (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .stage_valid   (stage_valid),
        .stage         (stage),
        .out_ready     (m_tready),
        .adv           (adv),
        .out_valid     (m_tvalid),
        .pixel_out     (pixel_out),
        .last_pixel    (m_tlast),
        .frame_changed (m_tuser)
    );

    assign m_tdata = {7'b0000000, pixel_out};

endmodule

@@ rtl/core/hilt_checker.sv @@
`include "hilditch_thinning_pass_defines.svh"

module hilt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // No result may be on offer in the cycle after reset
    `HILT_ASSERT_RST(a_reset_clears, !aresetn |=> !m_tvalid, "result valid after reset")

    // Frame-changed flag only rides on the frame's last pixel
    `HILT_ASSERT(a_changed_on_last, (m_tvalid && m_tuser) |-> m_tlast, "changed without last")

    // A fresh result follows an accepted pixel through the window stage and the output register
    `HILT_ASSERT(a_rise_after_input, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2), "result without input")

    // A stalled result holds
    `HILT_ASSERT(a_stall_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)), "stalled result changed")

endmodule

bind hilditch_thinning_pass hilt_checker u_hilt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

@@ verif/tb_hilditch_thinning_pass.sv @@
`timescale 1ns / 1ps

module tb_hilditch_thinning_pass;

    // Outcome of one thinned pixel as it should leave the block
    typedef struct packed {
        bit pixel;
        bit last;
        bit changed;
    } thin_result_t;

    localparam int unsigned DRAIN_LIMIT = 100000;

    logic                              aclk        = 1'b0;
    logic                              aresetn     = 1'b0;
    logic                              s_tvalid    = 1'b0;
    logic                              s_tready;
    logic [7:0]                        s_tdata     = '0;     // [0] pixel_in, [7:1] zero
    logic                              s_tuser     = 1'b0;   // [0] flush
    logic                              m_tvalid;
    logic                              m_tready    = 1'b0;
    logic [7:0]                        m_tdata;              // [0] pixel_out, [7:1] zero
    logic                              m_tlast;
    logic                              m_tuser;              // [0] frame_changed
    logic                              cfg_wr_en   = 1'b0;
    hilt_pkg::cfg_reg_t                cfg_addr    = hilt_pkg::REG_IMAGE_WIDTH;
    logic [hilt_pkg::CFG_DATA_W-1:0]   cfg_wr_data = '0;

    // Idling percentages of the current phase
    int unsigned src_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;

    int unsigned pixels_sent = 0;
    int unsigned mismatches  = 0;

    // Mirror of the thinning pass
    logic [hilt_pkg::WIDTH_REG_W-1:0]  thin_width_reg  = hilt_pkg::WIDTH_REG_W'(1024);
    logic [hilt_pkg::HEIGHT_REG_W-1:0] thin_height_reg = hilt_pkg::HEIGHT_REG_W'(1024);
    logic [hilt_pkg::LINE_W-1:0]       thin_line [hilt_pkg::MAX_WIDTH] = '{default: '0};
    logic [hilt_pkg::WIN_W-1:0]        thin_window  = '0;
    int unsigned                       thin_in_col  = 0;
    int unsigned                       thin_in_row  = 0;
    int unsigned                       thin_out_col = 0;
    int unsigned                       thin_out_row = 0;
    bit                                thin_any_removed = 1'b0;

    thin_result_t expected_thinned [$];

    hilditch_thinning_pass DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned thin_eff_width();
        if (thin_width_reg == 0) return 1;
        if (thin_width_reg > hilt_pkg::MAX_WIDTH) return hilt_pkg::MAX_WIDTH;
        return thin_width_reg;
    endfunction

    function automatic int unsigned thin_eff_height();
        if (thin_height_reg == 0) return 1;
        if (thin_height_reg > hilt_pkg::MAX_HEIGHT) return hilt_pkg::MAX_HEIGHT;
        return thin_height_reg;
    endfunction

    // Window cell, white outside the 4x4 window
    function automatic bit win_bit(logic [hilt_pkg::WIN_W-1:0] win, int i, int j);
        if (i < 0 || i > 3 || j < 0 || j > 3) return 1'b0;
        return win[i*4+j];
    endfunction

    // Ring from bit 0 up: up, up-left, left, down-left, down, down-right, right, up-right
    function automatic logic [7:0] ring_of(logic [hilt_pkg::WIN_W-1:0] win, int a, int b);
        return {win_bit(win, a-1, b+1), win_bit(win, a, b+1), win_bit(win, a+1, b+1),
                win_bit(win, a+1, b), win_bit(win, a+1, b-1), win_bit(win, a, b-1),
                win_bit(win, a-1, b-1), win_bit(win, a-1, b)};
    endfunction

    // White-to-black steps round the ring
    function automatic int crossings_of(logic [7:0] nbr);
        int n;
        n = 0;
        for (int k = 0; k < 8; k++)
            if (!nbr[k] && nbr[(k+1)%8]) n++;
        return n;
    endfunction

    // Advance the mirror by one accepted pixel and queue the thinned pixel it releases
    function automatic void thin_accept_pixel(bit pixel, bit flush);
        int unsigned w, h, col;
        int r, c, nz;
        bit px, emit, center, removed, last, up, left, down, right, c1, c2, c3, c4;
        logic [hilt_pkg::LINE_W-1:0] old;
        logic [3:0] newcol, row_bits;
        logic [hilt_pkg::WIN_W-1:0] shifted, seen;
        logic [7:0] nbr;
        thin_result_t res;

        w = thin_eff_width();
        h = thin_eff_height();
        px = pixel & ~flush;
        col = (thin_in_col < hilt_pkg::MAX_WIDTH) ? thin_in_col : 0;
        old = thin_line[col];
        newcol = {px, old[0], old[1], old[2]};
        for (int i = 0; i < hilt_pkg::WIN_N; i++) begin
            row_bits = thin_window[i*4 +: 4];
            shifted[i*4 +: 4] = {newcol[i], row_bits[3:1]};
        end
        thin_window = shifted;
        thin_line[col] = {old[1:0], px};

        emit = (thin_in_row >= 2) || (thin_in_row == 1 && thin_in_col >= 1);
        if (thin_in_col + 1 >= w) begin
            thin_in_col = 0;
            if (thin_in_row < 'hFFFF) thin_in_row++;
        end else begin
            thin_in_col++;
        end
        if (!emit) return;

        // Blank every window cell that lies outside the image
        seen = '0;
        for (int i = 0; i < hilt_pkg::WIN_N; i++) begin
            for (int j = 0; j < hilt_pkg::WIN_N; j++) begin
                r = int'(thin_out_row) - 2 + i;
                c = int'(thin_out_col) - 2 + j;
                if (r >= 0 && r < int'(h) && c >= 0 && c < int'(w))
                    seen[i*4+j] = thin_window[i*4+j];
            end
        end

        center = seen[2*4+2];
        removed = 1'b0;
        if (center) begin
            nbr = ring_of(seen, 2, 2);
            nz = $countones(nbr);
            up = seen[1*4+2];
            left = seen[2*4+1];
            down = seen[3*4+2];
            right = seen[2*4+3];
            c1 = (nz >= 2) && (nz <= 6);
            c2 = crossings_of(nbr) == 1;
            c3 = !(up && left && right) || crossings_of(ring_of(seen, 1, 2)) != 1;
            c4 = !(up && left && down) || crossings_of(ring_of(seen, 2, 1)) != 1;
            removed = c1 && c2 && c3 && c4;
        end
        thin_any_removed |= removed;
        last = (thin_out_col + 1 >= w) && (thin_out_row + 1 >= h);

        res.pixel = center & ~removed;
        res.last = last;
        res.changed = last & thin_any_removed;
        expected_thinned.push_back(res);

        // Close the frame on its final pixel, otherwise step the output position
        if (last) begin
            thin_in_col = 0;
            thin_in_row = 0;
            thin_out_col = 0;
            thin_out_row = 0;
            thin_any_removed = 1'b0;
        end else if (thin_out_col + 1 >= w) begin
            thin_out_col = 0;
            if (thin_out_row < 'hFFFF) thin_out_row++;
        end else begin
            thin_out_col++;
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Predict on every input transaction
    always @(posedge aclk)
        if (aresetn && s_tvalid && s_tready)
            thin_accept_pixel(s_tdata[0], s_tuser);

    // Compare every output transaction with the oldest prediction
    always @(posedge aclk) begin
        thin_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_thinned.size() == 0) begin
                report_mismatch("unexpected result, pixel_out", m_tdata, 0);
            end else begin
                want = expected_thinned.pop_front();
                if (m_tdata !== {7'b0, want.pixel})
                    report_mismatch("pixel_out", m_tdata, want.pixel);
                if (m_tlast !== want.last)
                    report_mismatch("last_pixel", m_tlast, want.last);
                if (m_tuser !== want.changed)
                    report_mismatch("frame_changed", m_tuser, want.changed);
            end
        end
    end

    // Stall the result side at random
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    // Offer one pixel, idling first at random, and hold until the transaction
    task automatic send_pixel(bit pixel, bit flush);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, pixel};
        s_tuser  <= flush;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        pixels_sent++;
    endtask

    // Drive one register write and leave the enable for the caller to drop
    task automatic write_reg(hilt_pkg::cfg_reg_t idx, int unsigned value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value[hilt_pkg::CFG_DATA_W-1:0];
        @(posedge aclk);
        if (idx == hilt_pkg::REG_IMAGE_WIDTH) thin_width_reg = value[hilt_pkg::WIDTH_REG_W-1:0];
        else thin_height_reg = value[hilt_pkg::HEIGHT_REG_W-1:0];
    endtask

    task automatic set_image_size(int unsigned width_raw, int unsigned height_raw);
        write_reg(hilt_pkg::REG_IMAGE_WIDTH, width_raw);
        write_reg(hilt_pkg::REG_IMAGE_HEIGHT, height_raw);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold off the input until every predicted pixel has come back, then let the pipe settle
    task automatic wait_drained();
        int unsigned waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_thinned.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_thinned.size() != 0) begin
            report_mismatch("results never delivered", expected_thinned.size(), 0);
            expected_thinned.delete();
        end
        repeat (thin_eff_width() + 4) @(posedge aclk);
    endtask

    // One frame of w x h pixels, either random noise or a dense box on a sparse
    // background, followed by the w+1 drain transactions
    task automatic send_frame(int unsigned w, int unsigned h);
        int unsigned density, flush_pct, top, bot, lft, rgt;
        bit box, in_box, pixel;
        density = $urandom_range(100);
        flush_pct = ($urandom_range(3) == 0) ? 10 : 0;
        box = 1'($urandom_range(1));
        top = $urandom_range(h - 1);
        bot = $urandom_range(h - 1, top);
        lft = $urandom_range(w - 1);
        rgt = $urandom_range(w - 1, lft);
        for (int unsigned r = 0; r < h; r++) begin
            for (int unsigned c = 0; c < w; c++) begin
                in_box = box && r >= top && r <= bot && c >= lft && c <= rgt;
                if (in_box) pixel = $urandom_range(99) < 97;
                else pixel = $urandom_range(99) < (box ? density / 4 : density);
                send_pixel(pixel, $urandom_range(99) < flush_pct);
            end
        end
        // Drain items: mostly flush, pixel value is outside the image either way
        for (int unsigned k = 0; k <= w; k++)
            send_pixel(1'($urandom_range(1)), $urandom_range(3) != 0);
    endtask

    // Zero registers act as 1: a lone black pixel survives and nothing changes
    task automatic test_single_pixel();
        set_image_size(0, 0);
        send_pixel(1'b1, 1'b0);
        send_pixel(1'b1, 1'b0);
        send_pixel(1'b0, 1'b1);
        wait_drained();
    endtask

    // Solid 4x4 block with one black pixel flushed to white inside it
    task automatic test_solid_block_with_hole();
        set_image_size(4, 4);
        for (int k = 0; k < 16; k++)
            send_pixel(1'b1, k == 5);
        repeat (5) send_pixel(1'b0, 1'b1);
        wait_drained();
    endtask

    // Long thin frames: a single column, then a single row
    task automatic test_size_extremes();
        set_image_size(1, 40);
        send_frame(thin_eff_width(), thin_eff_height());
        wait_drained();
        set_image_size(40, 1);
        send_frame(thin_eff_width(), thin_eff_height());
        wait_drained();
    endtask

    // Random small frames over the idling phases, one to three frames per size
    task automatic test_random_frames();
        int unsigned src_plan [4]  = '{0, 77, 0, 27};
        int unsigned sink_plan [4] = '{0, 0, 77, 27};
        int unsigned start, w_raw, h_raw;
        for (int p = 0; p < 4; p++) begin
            src_idle_pct = src_plan[p];
            sink_stall_pct = sink_plan[p];
            start = pixels_sent;
            while (pixels_sent - start < 420) begin
                w_raw = ($urandom_range(7) == 0) ? $urandom_range(32, 9) : $urandom_range(8, 1);
                h_raw = ($urandom_range(7) == 0) ? $urandom_range(32, 9) : $urandom_range(8, 1);
                if (w_raw == 1 && $urandom_range(1)) w_raw = 0;
                if (h_raw == 1 && $urandom_range(1)) h_raw = 0;
                set_image_size(w_raw, h_raw);
                repeat ($urandom_range(3, 1)) send_frame(thin_eff_width(), thin_eff_height());
                wait_drained();
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_single_pixel();
        test_solid_block_with_hole();
        test_size_extremes();
        test_random_frames();
        if (mismatches == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    // Give up on a hung run
    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

endmodule
